// ===== rtl/sact_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sact_pkg
// Shared constants and types of the set-associative cache tag store.
// ----------------------------------------------------------------------------
package sact_pkg;
    localparam int WAYS_DEF     = 8;
    localparam int MAX_SETS_DEF = 1024;
    localparam int TAG_W        = 30;
    localparam int PAGE_SHIFT   = 12;
    localparam int CYCLES_PER_READ = 4;

    localparam logic [2:0] OC_HIT  = 3'd0;
    localparam logic [2:0] OC_COMP = 3'd1;
    localparam logic [2:0] OC_CONF = 3'd2;
    localparam logic [2:0] OC_SKIP = 3'd3;
    localparam logic [2:0] OC_INV  = 3'd4;

    localparam logic [2:0] REG_OFFSET = 3'd0;
    localparam logic [2:0] REG_INDEX  = 3'd1;
    localparam logic [2:0] REG_WAYS   = 3'd2;
    localparam logic [2:0] REG_RANDOM = 3'd3;
    localparam logic [2:0] REG_FILL   = 3'd4;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[15:1]};
    endfunction
endpackage
`default_nettype wire

// ===== rtl/sact_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sact_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_tag_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store
// Steps: each block touched by an access is read (S_READ), decided (S_DEC)
// and its result handed off; a conflict miss in random mode first reduces
// the LFSR by the way count in S_MOD; up to 5 blocks per request. An
// invalidate reads and decides each block of the 4 KiB frame (16 to 1024
// blocks), then gives the result. Address zero answers in the cycle after the request.
// Reset: a pass over all MAX_SETS sets clears valid bits and round-robin
// pointers; no request is accepted until it ends. Config writes always taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store
    import sact_pkg::*;
#(
    parameter int WAYS     = WAYS_DEF,
    parameter int MAX_SETS = MAX_SETS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_op,
    input  wire  [31:0] i_addr,
    input  wire  [4:0]  i_num_bytes,
    input  wire  [19:0] i_frame,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_outcome,
    output logic [8:0]  o_cycles,
    output logic [2:0]  o_way,
    output logic [9:0]  o_set_index,
    output logic [10:0] o_lines_invalidated,
    output logic        o_last
);
    localparam int SW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT = 1 + TAG_W;
    localparam int RW  = WAYS * ENT;
    localparam int LIM = $clog2(MAX_SETS);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_DEC, S_MOD, S_OUT} t_state;
    t_state r_state;

    logic [3:0] r_ob, r_ib, r_ways;
    logic       r_rand;
    logic [6:0] r_fill;
    logic [15:0] r_lfsr;

    logic        r_op;
    logic [31:0] r_blk;
    logic [2:0]  r_left;
    logic [10:0] r_icnt;
    logic [10:0] r_count;
    logic [SW-1:0] r_clr;
    logic [2:0]  r_rem;
    logic [1:0]  r_mstep;
    logic        r_mdone;

    logic [3:0] ob, ib, wy;
    logic [6:0] fl;
    always_comb begin
        ob = (r_ob < 4'd2) ? 4'd2 : (r_ob > 4'd8) ? 4'd8 : r_ob;
        ib = (r_ib > 4'(LIM)) ? 4'(LIM) : r_ib;
        wy = (r_ways == 4'd0) ? 4'd1 : (r_ways > 4'(WAYS)) ? 4'(WAYS) : r_ways;
        fl = (r_fill == 7'd0) ? 7'd1 : (r_fill > 7'd64) ? 7'd64 : r_fill;
    end

    logic [31:0] blk_m, setmask;
    logic [SW-1:0] set;
    logic [TAG_W-1:0] tag;
    always_comb begin
        setmask = (32'd1 << ib) - 32'd1;
        blk_m   = r_blk & (32'hFFFF_FFFF >> ob);
        set     = SW'(blk_m & setmask);
        tag     = TAG_W'(blk_m >> ib);
    end

    logic            ram_we, rr_we;
    logic [SW-1:0]   ram_addr;
    logic [RW-1:0]   ram_wd, ram_rd;
    logic [WW-1:0]   rr_wd, rr_rd;

    sact_ram #(.WIDTH(RW), .DEPTH(MAX_SETS)) u_lines (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wd), .o_rdata(ram_rd));
    sact_ram #(.WIDTH(WW), .DEPTH(MAX_SETS)) u_rr (
        .i_clk(i_clk), .i_we(rr_we), .i_addr(ram_addr),
        .i_wdata(rr_wd), .o_rdata(rr_rd));

    logic            hit, hasinv;
    logic [WW-1:0]   hw, iw, vic;
    logic [WW:0]     rrv;
    logic [15:0]     lnext;
    logic [WW-1:0]   rr_nx;
    always_comb begin
        hit = 1'b0; hasinv = 1'b0; hw = '0; iw = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w < int'(wy)) begin
                if (ram_rd[w*ENT+TAG_W] && ram_rd[w*ENT +: TAG_W] == tag) begin
                    hit = 1'b1; hw = WW'(w);
                end
                if (!ram_rd[w*ENT+TAG_W]) begin
                    hasinv = 1'b1; iw = WW'(w);
                end
            end
        end
        lnext = lfsr_step(r_lfsr);
        rrv   = (WW+1)'(rr_rd);
        if (rrv >= (WW+1)'(wy)) rrv = '0;
        rr_nx = WW'((rrv + 1'b1 == (WW+1)'(wy)) ? '0 : rrv + 1'b1);
        vic   = r_rand ? WW'(r_rem) : WW'(rrv);
    end

    // remainder of the next LFSR value by the way count, one nibble per cycle
    logic [3:0] nib, rm;
    logic [2:0] n_rem;
    always_comb begin
        nib = lnext[{r_mstep, 2'b00} +: 4];
        rm  = {1'b0, r_rem};
        for (int b = 3; b >= 0; b--) begin
            rm = {rm[2:0], nib[b]};
            if (rm >= wy) rm = rm - wy;
        end
        n_rem = rm[2:0];
    end

    logic need_mod;
    assign need_mod = !r_op && !hit && !hasinv && r_rand && !r_mdone;

    logic [2:0]  n_oc;
    logic [WW-1:0] n_way;
    logic [RW-1:0] n_row;
    always_comb begin
        n_row = ram_rd;
        n_way = '0;
        n_oc  = OC_HIT;
        if (r_op) begin
            if (hit) n_row[hw*ENT+TAG_W] = 1'b0;
        end else if (hit) begin
            n_way = hw;
        end else if (hasinv) begin
            n_oc = OC_COMP; n_way = iw;
        end else begin
            n_oc = OC_CONF; n_way = vic;
        end
        if (!r_op && !hit) n_row[n_way*ENT +: ENT] = {1'b1, tag};
    end

    always_comb begin
        ram_we = 1'b0; rr_we = 1'b0; rr_wd = rr_nx;
        ram_addr = set; ram_wd = n_row;
        if (r_state == S_CLR) begin
            ram_addr = r_clr; ram_we = 1'b1; rr_we = 1'b1;
            ram_wd = '0; rr_wd = '0;
        end else if (r_state == S_DEC) begin
            ram_we = r_op ? hit : (!hit && !need_mod);
            rr_we  = !r_op && !hit && !hasinv && !r_rand;
        end
    end

    assign o_stall     = (r_state != S_IDLE) || o_valid;
    assign o_cfg_ready = 1'b1;

    logic [31:0] endaddr, firstb;
    always_comb begin
        endaddr = i_addr + 32'((i_num_bytes == 5'd0) ? 5'd1 :
                  (i_num_bytes > 5'd16) ? 5'd16 : i_num_bytes) - 32'd1;
        firstb  = i_addr >> ob;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; o_valid <= 1'b0;
            r_ob <= 4'd4; r_ib <= 4'd6; r_ways <= 4'd4; r_rand <= 1'b0;
            r_fill <= 7'd4; r_lfsr <= LFSR_SEED; r_mdone <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_OFFSET: r_ob   <= i_cfg_data[3:0];
                    REG_INDEX:  r_ib   <= i_cfg_data[3:0];
                    REG_WAYS:   r_ways <= i_cfg_data[3:0];
                    REG_RANDOM: r_rand <= i_cfg_data[0];
                    REG_FILL:   r_fill <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SW'(MAX_SETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid && !o_stall) begin
                    r_op <= i_op; r_count <= '0;
                    if (i_op) begin
                        r_blk  <= {i_frame, 12'd0} >> ob;
                        r_icnt <= 11'(13'd4096 >> ob);
                        r_state <= S_READ;
                    end else if (i_addr == 32'd0) begin
                        o_valid <= 1'b1; o_outcome <= OC_SKIP; o_cycles <= '0;
                        o_way <= '0; o_set_index <= '0;
                        o_lines_invalidated <= '0; o_last <= 1'b1;
                    end else begin
                        r_blk  <= firstb;
                        r_left <= 3'((endaddr >> ob) - firstb);
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_DEC;
                S_DEC: begin
                    if (r_op) begin
                        r_blk <= r_blk + 32'd1;
                        r_icnt <= r_icnt - 11'd1;
                        if (hit) r_count <= r_count + 11'd1;
                        if (r_icnt == 11'd1) begin
                            o_valid <= 1'b1; o_outcome <= OC_INV; o_cycles <= '0;
                            o_way <= '0; o_set_index <= '0; o_last <= 1'b1;
                            o_lines_invalidated <= r_count + 11'(hit);
                            r_state <= S_IDLE;
                        end else r_state <= S_READ;
                    end else if (need_mod) begin
                        r_rem <= '0; r_mstep <= 2'd3;
                        r_state <= S_MOD;
                    end else begin
                        r_blk <= r_blk + 32'd1;
                        r_mdone <= 1'b0;
                        if (!hit && !hasinv && r_rand) r_lfsr <= lnext;
                        o_valid <= 1'b1; o_outcome <= n_oc;
                        o_cycles <= hit ? 9'd1 : 9'(fl) * 9'(CYCLES_PER_READ);
                        o_way <= 3'(n_way); o_set_index <= 10'(set);
                        o_lines_invalidated <= '0; o_last <= (r_left == 3'd0);
                        r_left <= r_left - 3'd1;
                        r_state <= (r_left == 3'd0) ? S_IDLE : S_OUT;
                    end
                end
                S_MOD: begin
                    r_rem <= n_rem;
                    r_mstep <= r_mstep - 2'd1;
                    if (r_mstep == 2'd0) begin
                        r_mdone <= 1'b1;
                        r_state <= S_DEC;
                    end
                end
                S_OUT: if (!o_valid || !i_stall) r_state <= S_READ;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = ^{i_cfg_data[31:7]};
endmodule
`default_nettype wire
